FILE: rtl/nhs_pkg.sv
// nhs_pkg: shared types and constants for the top-n heap selector
// used by nhs_cell, nhs_ctrl and top_n_heap_selector; no dependencies
package nhs_pkg;

	localparam int CAPACITY_DEF  = 16;
	localparam int KEY_WIDTH_DEF = 32;
	localparam int IN_KEY_W      = 32;
	localparam int TAG_W         = 16;
	localparam int ORD_W         = 32;
	localparam int LIMIT_W       = 5;
	localparam int CFG_INDEX_W   = 1;
	localparam int CFG_DATA_W    = 5;

	typedef enum logic {
		FUNC_ADD    = 1'b0,
		FUNC_FINISH = 1'b1
	} func_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KEEP_LIMIT     = 1'd0,
		REG_COMPARE_ENABLE = 1'd1
	} cfg_reg_t;

	// what a pass through the cell row looks for
	typedef enum logic [1:0] {
		PASS_MAX,
		PASS_MIN,
		PASS_FIRST
	} pass_mode_t;

	// control part of the link between neighboring cells
	typedef struct packed {
		logic go;
		logic found;
	} link_ctl_t;

	// command broadcast from the sequencer to every cell
	typedef struct packed {
		logic       wr_en;
		logic       mark_en;
		logic       clear_used;
		pass_mode_t mode;
	} cell_cmd_t;

endpackage

FILE: rtl/top_n_heap_selector.sv
// top_n_heap_selector: top level; a sequencer and a row of CAPACITY cells
// linked by registered candidate stages; uses nhs_pkg, nhs_cell and nhs_ctrl
//
// Keeps the keep_limit smallest rows (key, then arrival order) of a stream and
// emits them in ascending order on a finish, with last on the final row; with
// compare_enable low the first rows are kept and emitted in arrival order.
// An add that still fits is written straight into a cell, so such rows stream at
// one per cycle while in_stall is low. An add into a full store runs one pass
// down the cell row to find the largest kept row and stalls the input until
// that pass returns. A finish emits each kept row after its own pass, and an
// empty finish runs no pass. The pass length is set by the row of CAPACITY
// cells, each adding one register stage to the candidate path. A waiting result
// does not stall the input; only the next drain row waits for the output slot.
module top_n_heap_selector #(
	parameter int CAPACITY  = nhs_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = nhs_pkg::KEY_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [nhs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [nhs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            func,
	input  logic [nhs_pkg::IN_KEY_W-1:0]    sort_key,
	input  logic [nhs_pkg::TAG_W-1:0]       row_tag,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [nhs_pkg::IN_KEY_W-1:0]    out_key,
	output logic [nhs_pkg::TAG_W-1:0]       out_tag,
	output logic                            last
);
	import nhs_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	cell_cmd_t            cmd;
	logic [IW-1:0]        cmd_idx;
	logic [CW-1:0]        count;
	logic [KEY_WIDTH-1:0] wr_key;
	logic [TAG_W-1:0]     wr_tag;
	logic [ORD_W-1:0]     wr_ord;

	// link[0] is the seed, link[CAPACITY] the result of a pass
	link_ctl_t            link_ctl [CAPACITY+1];
	logic [KEY_WIDTH-1:0] link_key [CAPACITY+1];
	logic [TAG_W-1:0]     link_tag [CAPACITY+1];
	logic [ORD_W-1:0]     link_ord [CAPACITY+1];
	logic [IW-1:0]        link_idx [CAPACITY+1];

	assign link_key[0] = '0;
	assign link_tag[0] = '0;
	assign link_ord[0] = '0;
	assign link_idx[0] = '0;

	nhs_ctrl #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.sort_key  (sort_key),
		.row_tag   (row_tag),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_key   (out_key),
		.out_tag   (out_tag),
		.last      (last),
		.cmd       (cmd),
		.cmd_idx   (cmd_idx),
		.count     (count),
		.wr_key    (wr_key),
		.wr_tag    (wr_tag),
		.wr_ord    (wr_ord),
		.seed_ctl  (link_ctl[0]),
		.end_ctl   (link_ctl[CAPACITY]),
		.end_key   (link_key[CAPACITY]),
		.end_tag   (link_tag[CAPACITY]),
		.end_idx   (link_idx[CAPACITY])
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		nhs_cell #(
			.CAPACITY  (CAPACITY),
			.KEY_WIDTH (KEY_WIDTH),
			.IDX       (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.cmd_idx  (cmd_idx),
			.count    (count),
			.wr_key   (wr_key),
			.wr_tag   (wr_tag),
			.wr_ord   (wr_ord),
			.prev_ctl (link_ctl[i]),
			.prev_key (link_key[i]),
			.prev_tag (link_tag[i]),
			.prev_ord (link_ord[i]),
			.prev_idx (link_idx[i]),
			.next_ctl (link_ctl[i+1]),
			.next_key (link_key[i+1]),
			.next_tag (link_tag[i+1]),
			.next_ord (link_ord[i+1]),
			.next_idx (link_idx[i+1])
		);
	end

endmodule

FILE: rtl/nhs_cell.sv
// nhs_cell: one storage cell of the row; holds one kept row and forwards the
// running best candidate of a pass to its neighbor; depends on nhs_pkg
module nhs_cell #(
	parameter int CAPACITY  = nhs_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = nhs_pkg::KEY_WIDTH_DEF,
	parameter int IDX       = 0
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  nhs_pkg::cell_cmd_t                            cmd,
	input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] cmd_idx,
	input  logic [$clog2(CAPACITY + 1)-1:0]               count,
	input  logic [KEY_WIDTH-1:0]                          wr_key,
	input  logic [nhs_pkg::TAG_W-1:0]                     wr_tag,
	input  logic [nhs_pkg::ORD_W-1:0]                     wr_ord,
	input  nhs_pkg::link_ctl_t                            prev_ctl,
	input  logic [KEY_WIDTH-1:0]                          prev_key,
	input  logic [nhs_pkg::TAG_W-1:0]                     prev_tag,
	input  logic [nhs_pkg::ORD_W-1:0]                     prev_ord,
	input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] prev_idx,
	output nhs_pkg::link_ctl_t                            next_ctl,
	output logic [KEY_WIDTH-1:0]                          next_key,
	output logic [nhs_pkg::TAG_W-1:0]                     next_tag,
	output logic [nhs_pkg::ORD_W-1:0]                     next_ord,
	output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] next_idx
);
	import nhs_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);
	localparam logic [CW-1:0] MY_POS = CW'(IDX);

	logic [KEY_WIDTH-1:0] key_q;
	logic [TAG_W-1:0]     tag_q;
	logic [ORD_W-1:0]     ord_q;
	logic                 used_q;

	link_ctl_t            ctl_q;
	logic [KEY_WIDTH-1:0] lkey_q;
	logic [TAG_W-1:0]     ltag_q;
	logic [ORD_W-1:0]     lord_q;
	logic [IW-1:0]        lidx_q;

	logic hit;
	logic eligible;
	logic mine_gt;
	logic mine_lt;
	logic better;
	logic take;

	assign hit      = (cmd_idx == MY_IDX);
	assign eligible = (count > MY_POS) && !used_q;

	// key first, arrival number breaks ties
	assign mine_gt = (key_q > prev_key) || ((key_q == prev_key) && (ord_q > prev_ord));
	assign mine_lt = (key_q < prev_key) || ((key_q == prev_key) && (ord_q < prev_ord));

	always_comb begin
		case (cmd.mode)
			PASS_MAX: better = mine_gt;
			PASS_MIN: better = mine_lt;
			default:  better = 1'b0;
		endcase
	end

	assign take = prev_ctl.go && eligible && (!prev_ctl.found || better);

	always_ff @(posedge clk) begin
		if (cmd.wr_en && hit) begin
			key_q <= wr_key;
			tag_q <= wr_tag;
			ord_q <= wr_ord;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			ctl_q  <= '0;
		end else begin
			if (cmd.clear_used) begin
				used_q <= 1'b0;
			end else if (cmd.mark_en && hit) begin
				used_q <= 1'b1;
			end
			ctl_q.go    <= prev_ctl.go;
			ctl_q.found <= prev_ctl.found || take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			lkey_q <= key_q;
			ltag_q <= tag_q;
			lord_q <= ord_q;
			lidx_q <= MY_IDX;
		end else begin
			lkey_q <= prev_key;
			ltag_q <= prev_tag;
			lord_q <= prev_ord;
			lidx_q <= prev_idx;
		end
	end

	assign next_ctl = ctl_q;
	assign next_key = lkey_q;
	assign next_tag = ltag_q;
	assign next_ord = lord_q;
	assign next_idx = lidx_q;

endmodule

FILE: rtl/nhs_ctrl.sv
// nhs_ctrl: sequencer of the selector; configuration registers, input and
// output handshakes, fill count, arrival counter and pass launching; uses nhs_pkg
module nhs_ctrl #(
	parameter int CAPACITY  = nhs_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = nhs_pkg::KEY_WIDTH_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_we,
	input  logic [nhs_pkg::CFG_INDEX_W-1:0]               cfg_index,
	input  logic [nhs_pkg::CFG_DATA_W-1:0]                cfg_data,
	input  logic                                          in_valid,
	output logic                                          in_stall,
	input  logic                                          func,
	input  logic [nhs_pkg::IN_KEY_W-1:0]                  sort_key,
	input  logic [nhs_pkg::TAG_W-1:0]                     row_tag,
	output logic                                          out_valid,
	input  logic                                          out_stall,
	output logic [nhs_pkg::IN_KEY_W-1:0]                  out_key,
	output logic [nhs_pkg::TAG_W-1:0]                     out_tag,
	output logic                                          last,
	output nhs_pkg::cell_cmd_t                            cmd,
	output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] cmd_idx,
	output logic [$clog2(CAPACITY + 1)-1:0]               count,
	output logic [KEY_WIDTH-1:0]                          wr_key,
	output logic [nhs_pkg::TAG_W-1:0]                     wr_tag,
	output logic [nhs_pkg::ORD_W-1:0]                     wr_ord,
	output nhs_pkg::link_ctl_t                            seed_ctl,
	input  nhs_pkg::link_ctl_t                            end_ctl,
	input  logic [KEY_WIDTH-1:0]                          end_key,
	input  logic [nhs_pkg::TAG_W-1:0]                     end_tag,
	input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] end_idx
);
	import nhs_pkg::*;

	localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DSEED,
		ST_DWAIT
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic [ORD_W-1:0]     ctr_q;
	logic [CW-1:0]        k_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic                 cmp_q;
	pass_mode_t           mode_q;
	logic                 seed_q;
	logic [KEY_WIDTH-1:0] pend_key_q;
	logic [TAG_W-1:0]     pend_tag_q;
	logic [ORD_W-1:0]     pend_ord_q;
	logic                 out_valid_q;
	logic [IN_KEY_W-1:0]  out_key_q;
	logic [TAG_W-1:0]     out_tag_q;
	logic                 last_q;

	logic                 in_take;
	logic                 is_add;
	logic                 below_lim;
	logic [KEY_WIDTH-1:0] in_key_w;
	logic [ORD_W-1:0]     ctr_nxt;
	logic                 replace;
	logic                 drain_load;
	logic                 drain_last;
	logic                 out_free;

	assign in_take    = in_valid && (state_q == ST_IDLE);
	assign is_add     = (func == FUNC_ADD);
	assign below_lim  = (CMPW'(count_q) < CMPW'(limit_q)) && (count_q < CW'(CAPACITY));
	assign in_key_w   = KEY_WIDTH'(sort_key);
	assign ctr_nxt    = ctr_q + ORD_W'(1);
	// new row wins only on a strictly smaller key
	assign replace    = (state_q == ST_SCAN) && end_ctl.go && end_ctl.found
		&& (pend_key_q < end_key);
	assign drain_load = (state_q == ST_DWAIT) && end_ctl.go;
	assign drain_last = ((k_q + CW'(1)) == count_q);
	assign out_free   = !out_valid_q || !out_stall;

	always_comb begin
		cmd.wr_en      = (in_take && is_add && below_lim) || replace;
		cmd.mark_en    = drain_load;
		cmd.clear_used = drain_load && drain_last;
		cmd.mode       = mode_q;
		if (replace || drain_load) begin
			cmd_idx = end_idx;
		end else begin
			cmd_idx = count_q[IW-1:0];
		end
		if (replace) begin
			wr_key = pend_key_q;
			wr_tag = pend_tag_q;
			wr_ord = pend_ord_q;
		end else begin
			wr_key = in_key_w;
			wr_tag = row_tag;
			wr_ord = ctr_nxt;
		end
	end

	assign seed_ctl = '{go: seed_q, found: 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ctr_q       <= '0;
			k_q         <= '0;
			limit_q     <= LIMIT_W'(16);
			cmp_q       <= 1'b1;
			mode_q      <= PASS_MAX;
			seed_q      <= 1'b0;
			pend_key_q  <= '0;
			pend_tag_q  <= '0;
			pend_ord_q  <= '0;
			out_valid_q <= 1'b0;
			out_key_q   <= '0;
			out_tag_q   <= '0;
			last_q      <= 1'b0;
		end else begin
			seed_q <= 1'b0;

			if (cfg_we) begin
				case (cfg_index)
					REG_KEEP_LIMIT:     limit_q <= cfg_data[LIMIT_W-1:0];
					REG_COMPARE_ENABLE: cmp_q   <= cfg_data[0];
					default:            ;
				endcase
			end

			if (drain_load) begin
				out_valid_q <= 1'b1;
				out_key_q   <= IN_KEY_W'(end_key);
				out_tag_q   <= end_tag;
				last_q      <= drain_last;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (is_add) begin
							ctr_q <= ctr_nxt;
							if (below_lim) begin
								count_q <= count_q + CW'(1);
							end else if (cmp_q && (count_q != '0) && (limit_q != '0)) begin
								pend_key_q <= in_key_w;
								pend_tag_q <= row_tag;
								pend_ord_q <= ctr_nxt;
								mode_q     <= PASS_MAX;
								seed_q     <= 1'b1;
								state_q    <= ST_SCAN;
							end
						end else begin
							ctr_q <= '0;
							if (count_q != '0) begin
								mode_q  <= cmp_q ? PASS_MIN : PASS_FIRST;
								k_q     <= '0;
								state_q <= ST_DSEED;
							end
						end
					end
				end
				ST_SCAN: begin
					if (end_ctl.go) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DSEED: begin
					// the slot is empty by the time the pass comes back
					if (out_free) begin
						seed_q  <= 1'b1;
						state_q <= ST_DWAIT;
					end
				end
				ST_DWAIT: begin
					if (end_ctl.go) begin
						k_q <= k_q + CW'(1);
						if (drain_last) begin
							count_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DSEED;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_key   = out_key_q;
	assign out_tag   = out_tag_q;
	assign last      = last_q;
	assign count     = count_q;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	a_end_state: assert property (@(posedge clk) disable iff (!arst_n)
		end_ctl.go |-> (state_q == ST_SCAN || state_q == ST_DWAIT))
		else $error("pass result arrived with no pass pending");

	a_drain_found: assert property (@(posedge clk) disable iff (!arst_n)
		drain_load |-> end_ctl.found)
		else $error("drain pass found no unused row");

	a_seed_single: assert property (@(posedge clk) disable iff (!arst_n)
		seed_q |=> !seed_q)
		else $error("two passes launched back to back");

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		drain_load |-> !out_valid_q)
		else $error("drained row overwrites a pending result");

endmodule
